### src/arpc_pkg.sv
// shared types and constants for the arp cache responder
// used by arpc_cell and arp_cache_responder, depends on nothing else
package arpc_pkg;

	localparam int IP_W  = 32;
	localparam int MAC_W = 48;
	localparam int OPC_W = 16;
	localparam int CFG_W = 48;

	localparam logic [OPC_W-1:0] OP_REQUEST = 16'd1;
	localparam logic [OPC_W-1:0] OP_REPLY   = 16'd2;

	// configuration register indexes
	localparam logic CFG_OWN_IP  = 1'b0;
	localparam logic CFG_OWN_MAC = 1'b1;

	// search token handed from cell to cell
	typedef struct packed {
		logic             valid;
		logic [IP_W-1:0]  key;
		logic             found;
		logic [MAC_W-1:0] mac;
	} probe_t;

	// pair broadcast to the cells for a table write
	typedef struct packed {
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
	} wr_t;

endpackage

### src/arpc_cell.sv
// one table entry of the arp cache with its stage of the search chain
// depends on arpc_pkg
module arpc_cell import arpc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  probe_t probe_in,
	output probe_t probe_out,
	input  logic   wr_en,
	input  wr_t    wr
);

	logic [IP_W-1:0]  addr_q;
	logic [MAC_W-1:0] mac_q;
	probe_t           probe_q;
	probe_t           probe_d;

	// first matching cell along the chain claims the probe
	always_comb begin
		probe_d = probe_in;
		if (probe_in.valid && !probe_in.found && probe_in.key == addr_q) begin
			probe_d.found = 1'b1;
			probe_d.mac   = mac_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			mac_q   <= '0;
			probe_q <= '0;
		end else begin
			probe_q <= probe_d;
			if (wr_en) begin
				addr_q <= wr.ip;
				mac_q  <= wr.mac;
			end
		end
	end

	assign probe_out = probe_q;

endmodule

### src/arp_cache_responder.sv
// top level of the arp cache responder: request control, learning and result register
// depends on arpc_pkg and arpc_cell
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------------
//  in       | in_valid/in_stall  | operation, arp_opcode, src_ip, src_mac,
//           |                    | tgt_ip, query_ip
//  out      | out_valid/out_stall| hit, found_mac, send_reply, reply_dest_mac,
//           |                    | reply_dest_ip, odd_opcode, learned
//  cfg      | cfg_we             | cfg_index, cfg_data
//
// from acceptance the probe passes one cell per cycle through the chain; the result is then
// staged in pend_q and loaded into the output register once the output is free.
// one request is in work at a time; the next may be accepted while the result waits.
// reset clears every entry to zero, the slot pointer and all control state at once.
// a stall on the output holds the result; a further request may search meanwhile and
// then waits with its result staged until the output frees.
module arp_cache_responder import arpc_pkg::*; #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             operation,
	input  logic [OPC_W-1:0] arp_opcode,
	input  logic [IP_W-1:0]  src_ip,
	input  logic [MAC_W-1:0] src_mac,
	input  logic [IP_W-1:0]  tgt_ip,
	input  logic [IP_W-1:0]  query_ip,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             hit,
	output logic [MAC_W-1:0] found_mac,
	output logic             send_reply,
	output logic [MAC_W-1:0] reply_dest_mac,
	output logic [IP_W-1:0]  reply_dest_ip,
	output logic             odd_opcode,
	output logic             learned
);

	localparam int SLOT_W = $clog2(TABLE_ENTRIES);

	typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_HOLD} state_t;

	typedef struct packed {
		logic             hit;
		logic [MAC_W-1:0] found_mac;
		logic             send_reply;
		logic [MAC_W-1:0] reply_dest_mac;
		logic [IP_W-1:0]  reply_dest_ip;
		logic             odd_opcode;
		logic             learned;
	} res_t;

	state_t            state_q;
	logic [IP_W-1:0]   own_ip_q;
	logic [SLOT_W-1:0] next_slot_q;
	logic              op_q;
	logic [OPC_W-1:0]  opcode_q;
	logic [IP_W-1:0]   sip_q;
	logic [MAC_W-1:0]  smac_q;
	logic [IP_W-1:0]   tip_q;
	res_t              pend_q;
	res_t              out_q;
	logic              out_valid_q;
	res_t              res_d;

	probe_t                   chain [TABLE_ENTRIES+1];
	probe_t                   head;
	logic [TABLE_ENTRIES-1:0] probe_vld;
	probe_t                   tail;
	logic                     accept;
	logic                     learn_we;
	logic                     is_req;
	logic                     load_out;
	wr_t                      wr;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	// inject the probe into the head of the chain
	always_comb begin
		head       = '0;
		head.valid = accept;
		head.key   = operation ? query_ip : src_ip;
	end

	assign chain[0] = head;

	assign wr.ip  = sip_q;
	assign wr.mac = smac_q;

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
			arpc_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.probe_in  (chain[gi]),
				.probe_out (chain[gi+1]),
				.wr_en     (learn_we && next_slot_q == SLOT_W'(gi)),
				.wr        (wr)
			);
			assign probe_vld[gi] = chain[gi+1].valid;
		end
	endgenerate

	assign tail     = chain[TABLE_ENTRIES];
	assign learn_we = (state_q == S_SEARCH) && tail.valid && !op_q && !tail.found;
	assign is_req   = (opcode_q == OP_REQUEST);
	assign load_out = (state_q == S_HOLD) && (!out_valid_q || !out_stall);

	always_comb begin
		res_d = '0;
		if (op_q) begin
			res_d.hit       = tail.found;
			res_d.found_mac = tail.mac;
		end else begin
			if (is_req && tip_q == own_ip_q) begin
				res_d.send_reply     = 1'b1;
				res_d.reply_dest_mac = smac_q;
				res_d.reply_dest_ip  = sip_q;
			end
			res_d.odd_opcode = !is_req && (opcode_q != OP_REPLY);
			res_d.learned    = !tail.found;
		end
	end

	// own_mac is not kept in this block; a write to CFG_OWN_MAC changes nothing here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OWN_IP:  own_ip_q <= cfg_data[IP_W-1:0];
				CFG_OWN_MAC: own_ip_q <= own_ip_q;
				default:     own_ip_q <= own_ip_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			next_slot_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (learn_we) begin
				if (next_slot_q == SLOT_W'(TABLE_ENTRIES - 1)) begin
					next_slot_q <= '0;
				end else begin
					next_slot_q <= next_slot_q + SLOT_W'(1);
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (tail.valid) begin
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= operation;
			opcode_q <= arp_opcode;
			sip_q    <= src_ip;
			smac_q   <= src_mac;
			tip_q    <= tgt_ip;
		end
		if (state_q == S_SEARCH && tail.valid) begin
			pend_q <= res_d;
		end
		if (load_out) begin
			out_q <= pend_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign hit            = out_q.hit;
	assign found_mac      = out_q.found_mac;
	assign send_reply     = out_q.send_reply;
	assign reply_dest_mac = out_q.reply_dest_mac;
	assign reply_dest_ip  = out_q.reply_dest_ip;
	assign odd_opcode     = out_q.odd_opcode;
	assign learned        = out_q.learned;

	// only one probe travels the chain at a time
	a_one_probe: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(probe_vld))
		else $error("more than one probe in the chain");

	a_tail_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> state_q == S_SEARCH)
		else $error("probe left the chain outside a search");

	a_accept_search: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_SEARCH && probe_vld[0])
		else $error("accepted request did not start a search");

	a_slot_moves: assert property (@(posedge clk) disable iff (!arst_n)
		learn_we |=> next_slot_q != $past(next_slot_q))
		else $error("slot pointer did not advance after a learn");

endmodule
